### design/palcc_pkg.sv
package palcc_pkg;

  localparam int CHANNELS    = 32;
  localparam int TABLE_DEPTH = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAN_W  = 5;
  localparam int ENTRY_W = 7;
  localparam int COLOR_W = 12;
  localparam int LSTEP_W = 7;
  localparam int SPEED_W = 8;
  localparam int BLEND_W = 8;
  localparam int POS_W   = 8;
  localparam int FUNC_W  = 3;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TBL_SIZE = CHANNELS * TABLE_DEPTH;
  localparam int TBL_AW   = $clog2(TBL_SIZE);
  localparam int QP_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STATIC = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BLEND  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SETPOS = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd6;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_LOAD,
    OP_START,
    OP_STATIC,
    OP_BLEND,
    OP_SETPOS,
    OP_STOP
  } op_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAN_W-1:0]  channel;
    logic [ENTRY_W-1:0] entry;
    logic [COLOR_W-1:0] color;
    logic [LSTEP_W-1:0] last_step;
    logic [SPEED_W-1:0] speed;
    logic [BLEND_W-1:0] blend;
  } cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [COLOR_W-1:0] out_color;
    logic               last;
  } result_t;

  typedef struct packed {
    op_e                op;
    logic [CHAN_W-1:0]  channel;
    logic [ENTRY_W-1:0] entry;
    logic [COLOR_W-1:0] color;
    logic [LSTEP_W-1:0] last_step;
    logic [SPEED_W-1:0] speed;
    logic [BLEND_W-1:0] blend;
  } q_item_t;

endpackage

### design/palcc_front.sv
module palcc_front (
  input  logic              start_i,
  input  logic              busy_i,
  input  logic              cyc_en_i,
  input  palcc_pkg::cmd_t   cmd_i,
  output logic              push_o,
  output palcc_pkg::q_item_t item_o
);

  logic ch_ok;
  logic entry_ok;
  logic keep;

  assign ch_ok    = int'(cmd_i.channel) < palcc_pkg::CHANNELS;
  assign entry_ok = int'(cmd_i.entry) < palcc_pkg::TABLE_DEPTH;

  // commands that cannot change anything are dropped here
  always_comb begin
    item_o.op        = palcc_pkg::OP_TICK;
    item_o.channel   = cmd_i.channel;
    item_o.entry     = cmd_i.entry;
    item_o.color     = cmd_i.color;
    item_o.last_step = cmd_i.last_step;
    item_o.speed     = cmd_i.speed;
    item_o.blend     = cmd_i.blend;
    keep             = 1'b0;
    case (cmd_i.func)
      palcc_pkg::FUNC_TICK: begin
        item_o.op = palcc_pkg::OP_TICK;
        keep      = cyc_en_i;
      end
      palcc_pkg::FUNC_LOAD: begin
        item_o.op = palcc_pkg::OP_LOAD;
        keep      = ch_ok && entry_ok;
      end
      palcc_pkg::FUNC_START: begin
        item_o.op = palcc_pkg::OP_START;
        keep      = ch_ok;
      end
      palcc_pkg::FUNC_STATIC: begin
        item_o.op = palcc_pkg::OP_STATIC;
        keep      = ch_ok;
      end
      palcc_pkg::FUNC_BLEND: begin
        item_o.op = palcc_pkg::OP_BLEND;
        keep      = ch_ok;
      end
      palcc_pkg::FUNC_SETPOS: begin
        item_o.op = palcc_pkg::OP_SETPOS;
        keep      = ch_ok;
      end
      palcc_pkg::FUNC_STOP: begin
        item_o.op = palcc_pkg::OP_STOP;
        keep      = ch_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = start_i && !busy_i && keep;

endmodule

### design/palcc_queue.sv
module palcc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  palcc_pkg::q_item_t item_i,
  input  logic               pop_i,
  output palcc_pkg::q_item_t item_o,
  output logic               valid_o,
  output logic               full_o
);

  palcc_pkg::q_item_t                 slot_q [palcc_pkg::QUEUE_DEPTH];
  logic [palcc_pkg::QP_W-1:0]         wp_q, wp_d;
  logic [palcc_pkg::QP_W-1:0]         rp_q, rp_d;
  logic [palcc_pkg::QC_W-1:0]         cnt_q, cnt_d;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == palcc_pkg::QC_W'(palcc_pkg::QUEUE_DEPTH);
  assign item_o  = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == palcc_pkg::QP_W'(palcc_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == palcc_pkg::QP_W'(palcc_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= item_i;
    end
  end

endmodule

### design/palcc_back.sv
module palcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  palcc_pkg::q_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  output logic               clearing_o,
  output logic               res_strobe_o,
  output palcc_pkg::result_t res_o
);

  localparam int CH_W    = palcc_pkg::CH_W;
  localparam int POS_W   = palcc_pkg::POS_W;
  localparam int TBL_AW  = palcc_pkg::TBL_AW;
  localparam int COLOR_W = palcc_pkg::COLOR_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  function automatic logic [3:0] mix_comp(input logic [3:0] a, input logic [3:0] b,
                                          input logic [7:0] amt);
    logic signed [4:0]  d;
    logic signed [13:0] p;
    logic signed [13:0] q;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, amt});
    q = p >>> 8;
    mix_comp = a + q[3:0];
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [CH_W-1:0] ch,
                                                 input logic [POS_W-1:0] idx);
    tbl_addr = TBL_AW'(int'(ch) * palcc_pkg::TABLE_DEPTH + int'(idx));
  endfunction

  state_e                state_q, state_d;
  logic [CH_W-1:0]       w_q, w_d;
  logic [TBL_AW-1:0]     clr_q;

  // per-channel state
  logic                              en_q   [palcc_pkg::CHANNELS];
  logic [POS_W-1:0]                  pos_q  [palcc_pkg::CHANNELS];
  logic [palcc_pkg::LSTEP_W-1:0]     lastp_q[palcc_pkg::CHANNELS];
  logic [palcc_pkg::SPEED_W-1:0]     spd_q  [palcc_pkg::CHANNELS];
  logic [7:0]                        dly_q  [palcc_pkg::CHANNELS];
  logic [COLOR_W-1:0]                tgt_q  [palcc_pkg::CHANNELS];
  logic [palcc_pkg::BLEND_W-1:0]     amt_q  [palcc_pkg::CHANNELS];

  logic [COLOR_W-1:0]    tbl_mem [palcc_pkg::TBL_SIZE];
  logic                  mem_we;
  logic [TBL_AW-1:0]     mem_waddr;
  logic [COLOR_W-1:0]    mem_wdata;
  logic [TBL_AW-1:0]     mem_raddr;
  logic [COLOR_W-1:0]    rdata_q;

  logic [CH_W-1:0]       hch;
  logic [7:0]            dly_inc;
  logic                  step;
  logic [POS_W-1:0]      pos_inc;
  logic [POS_W-1:0]      pos_nxt;
  logic [POS_W-1:0]      setpos;

  logic                  s1_valid_q;
  logic [CH_W-1:0]       s1_ch_q;
  logic                  s1_zero_q;
  logic [palcc_pkg::BLEND_W-1:0] s1_amt_q;
  logic [COLOR_W-1:0]    s1_tgt_q;

  logic [COLOR_W-1:0]    base_color;
  logic [COLOR_W-1:0]    mixed_color;

  logic                  pend_valid_q;
  logic [CH_W-1:0]       pend_ch_q;
  logic [COLOR_W-1:0]    pend_color_q;

  logic                  res_strobe_q;
  palcc_pkg::result_t    res_q;

  logic                  static_pop;

  assign clearing_o   = state_q == ST_CLEAR;
  assign item_pop_o   = (state_q == ST_IDLE) && item_valid_i;
  assign static_pop   = item_pop_o && (item_i.op == palcc_pkg::OP_STATIC);
  assign hch          = CH_W'(item_i.channel);
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // walk step for the channel under w_q
  assign dly_inc = dly_q[w_q] + 8'd1;
  assign step    = en_q[w_q] && (dly_inc > spd_q[w_q]);
  assign pos_inc = pos_q[w_q] + 1'b1;
  assign pos_nxt = (pos_inc > {1'b0, lastp_q[w_q]}) ? '0 : pos_inc;
  assign setpos  = (item_i.entry > lastp_q[hch]) ? '0 : {1'b0, item_i.entry};

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == TBL_AW'(palcc_pkg::TBL_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_pop_o && item_i.op == palcc_pkg::OP_TICK) begin
          state_d = ST_WALK;
          w_d     = '0;
        end
      end
      ST_WALK: begin
        if (w_q == CH_W'(palcc_pkg::CHANNELS - 1)) begin
          state_d = ST_WAIT;
          w_d     = '0;
        end else begin
          w_d = w_q + 1'b1;
        end
      end
      ST_WAIT: begin
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      w_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < palcc_pkg::CHANNELS; i++) begin
        en_q[i]    <= 1'b0;
        pos_q[i]   <= '0;
        lastp_q[i] <= '0;
        spd_q[i]   <= '0;
        dly_q[i]   <= '0;
        tgt_q[i]   <= '0;
        amt_q[i]   <= '0;
      end
    end else begin
      if (state_q == ST_WALK && en_q[w_q]) begin
        if (step) begin
          dly_q[w_q] <= '0;
          pos_q[w_q] <= pos_nxt;
        end else begin
          dly_q[w_q] <= dly_inc;
        end
      end
      if (item_pop_o) begin
        case (item_i.op)
          palcc_pkg::OP_START: begin
            pos_q[hch]   <= '0;
            lastp_q[hch] <= item_i.last_step;
            spd_q[hch]   <= item_i.speed;
            dly_q[hch]   <= '0;
            en_q[hch]    <= 1'b1;
          end
          palcc_pkg::OP_STATIC, palcc_pkg::OP_STOP: begin
            en_q[hch] <= 1'b0;
          end
          palcc_pkg::OP_BLEND: begin
            tgt_q[hch] <= item_i.color;
            amt_q[hch] <= item_i.blend;
          end
          palcc_pkg::OP_SETPOS: begin
            pos_q[hch] <= setpos;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // table memory: cleared by a sweep after reset, loads while idle
  always_comb begin
    mem_we    = (state_q == ST_CLEAR) || (item_pop_o && item_i.op == palcc_pkg::OP_LOAD);
    mem_waddr = (state_q == ST_CLEAR) ? clr_q : tbl_addr(hch, {1'b0, item_i.entry});
    mem_wdata = (state_q == ST_CLEAR) ? '0 : item_i.color;
    mem_raddr = tbl_addr(w_q, pos_nxt);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= tbl_mem[mem_raddr];
  end

  // stage 1: channel stepped, table read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= (state_q == ST_WALK) && step;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q   <= w_q;
    s1_zero_q <= int'(pos_nxt) >= palcc_pkg::TABLE_DEPTH;
    s1_amt_q  <= amt_q[w_q];
    s1_tgt_q  <= tgt_q[w_q];
  end

  // stage 2: blend; a zero amount leaves the color as it is
  assign base_color  = s1_zero_q ? '0 : rdata_q;
  assign mixed_color = {mix_comp(base_color[11:8], s1_tgt_q[11:8], s1_amt_q),
                        mix_comp(base_color[7:4],  s1_tgt_q[7:4],  s1_amt_q),
                        mix_comp(base_color[3:0],  s1_tgt_q[3:0],  s1_amt_q)};

  // one color is held back so the final one of a tick can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= 1'b0;
      if (s1_valid_q) begin
        pend_valid_q <= 1'b1;
        res_strobe_q <= pend_valid_q;
      end else if (state_q == ST_FLUSH) begin
        pend_valid_q <= 1'b0;
        res_strobe_q <= pend_valid_q;
      end else if (static_pop) begin
        res_strobe_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      pend_ch_q         <= s1_ch_q;
      pend_color_q      <= mixed_color;
      res_q.out_channel <= palcc_pkg::CHAN_W'(pend_ch_q);
      res_q.out_color   <= pend_color_q;
      res_q.last        <= 1'b0;
    end else if (state_q == ST_FLUSH) begin
      res_q.out_channel <= palcc_pkg::CHAN_W'(pend_ch_q);
      res_q.out_color   <= pend_color_q;
      res_q.last        <= 1'b1;
    end else if (static_pop) begin
      res_q.out_channel <= item_i.channel;
      res_q.out_color   <= item_i.color;
      res_q.last        <= 1'b1;
    end
  end

endmodule

### design/palette_color_cycle_engine.sv
// Palette color cycling engine. A command is taken at a clock edge with start high and busy
// low, and goes through a two-entry queue to the execution engine, so apart from the table
// clear busy rises only when that queue is full. After reset the table memory (CHANNELS x
// TABLE_DEPTH = 4096 entries) is zeroed one entry per cycle with busy high, and the
// cycling_enabled register can be written meanwhile. A tick walks the channels one per
// cycle through the single read port of the table memory, then a wait and a flush state
// drain the blend stage; every other command is carried out as it is popped. Colors are
// presented for exactly one cycle with res_strobe_o and cannot be stalled by the receiver.
// A tick gives colors for the channels that step, in ascending channel order with last set
// on the final one; a static color command gives one color with last set.
module palette_color_cycle_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  palcc_pkg::cmd_t    cmd_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  output logic               res_strobe_o,
  output palcc_pkg::result_t res_o
);

  logic               cyc_en_q;
  logic               push;
  palcc_pkg::q_item_t push_item;
  logic               pop;
  palcc_pkg::q_item_t head_item;
  logic               head_valid;
  logic               q_full;
  logic               clearing;

  assign cfg_ready_o = 1'b1;
  assign busy        = clearing || q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cyc_en_q <= cfg_data_i;
    end
  end

  palcc_front u_front (
    .start_i  (start),
    .busy_i   (busy),
    .cyc_en_i (cyc_en_q),
    .cmd_i    (cmd_i),
    .push_o   (push),
    .item_o   (push_item)
  );

  palcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .valid_o (head_valid),
    .full_o  (q_full)
  );

  palcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .item_valid_i (head_valid),
    .item_pop_o   (pop),
    .clearing_o   (clearing),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

### design/palcc_checker.sv
module palcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy_i,
  input logic               res_strobe_i,
  input palcc_pkg::result_t res_i
);

  // table clear keeps the block busy right after reset
  assert property (@(posedge clk_i) !rst_ni |=> busy_i)
    else $error("not busy after reset");

  // colors of one tick come in ascending channel order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && !res_i.last ##1 res_strobe_i
    |-> res_i.out_channel > $past(res_i.out_channel))
    else $error("tick colors out of channel order");

  // the highest channel is always the final color of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && res_i.out_channel == palcc_pkg::CHAN_W'(palcc_pkg::CHANNELS - 1)
    |-> res_i.last)
    else $error("top channel color without last");

endmodule

bind palette_color_cycle_engine palcc_checker u_palcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy_i       (busy),
  .res_strobe_i (res_strobe_o),
  .res_i        (res_o)
);
